/* hdl/fhap_pkg.sv */
// Shared types and constants for the header axis-length parser.
// No dependencies; every other file in hdl/ depends on this package.
package fhap_pkg;

   localparam int CARD_LENGTH     = 80;
   localparam int CARDS_PER_BLOCK = 36;
   localparam int POS_WIDTH       = $clog2(CARD_LENGTH + 1);
   localparam int NUM_WIDTH       = $clog2(CARDS_PER_BLOCK + 1);

   localparam int MAG_WIDTH       = 32;
   localparam int PROD_WIDTH      = MAG_WIDTH + 4;
   localparam int AXIS_WIDTH      = 32;
   localparam int DEFAULT_WIDTH   = 16;
   localparam int KW_LEN_WIDTH    = 3;

   localparam logic [DEFAULT_WIDTH-1:0] DEFAULT_AXIS_RESET = 16'd1024;
   localparam logic [MAG_WIDTH-1:0]     MAG_CAP            = 32'h8000_0000;
   localparam logic [AXIS_WIDTH-1:0]    AXIS_MAX           = 32'h7FFF_FFFF;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_EQUALS = 8'h3D;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_KEY,
      PH_VALUE,
      PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {
      TK_PRE,
      TK_WS,
      TK_NUM,
      TK_STOP
   } tok_state_type;

   typedef struct packed {
      logic                 neg;
      logic [MAG_WIDTH-1:0] mag;
   } tok_val_type;

   typedef struct packed {
      logic pre_clear;
      logic feed;
      logic post_clear;
   } tok_ctl_type;

   typedef struct packed {
      logic restart;
      logic step;
      logic kill;
      logic post_clear;
   } kw_ctl_type;

   typedef struct packed {
      logic naxis1;
      logic naxis2;
      logic end_kw;
   } kw_hit_type;

endpackage

/* hdl/fhap_if.sv */
// Valid/ready channel interfaces for header bytes, results and the CSR write.
// Depends on fhap_pkg for field widths.
interface fhap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       start_of_stream;

   modport source (output valid, output header_byte, output start_of_stream, input ready);
   modport sink   (input valid, input header_byte, input start_of_stream, output ready);
endinterface

interface fhap_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fhap_pkg::AXIS_WIDTH-1:0] axis_width;
   logic signed [fhap_pkg::AXIS_WIDTH-1:0] axis_height;
   logic                                 width_defaulted;
   logic                                 height_defaulted;

   modport source (output valid, output axis_width, output axis_height,
                   output width_defaulted, output height_defaulted, input ready);
   modport sink   (input valid, input axis_width, input axis_height,
                   input width_defaulted, input height_defaulted, output ready);
endinterface

interface fhap_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fhap_pkg::DEFAULT_WIDTH-1:0] default_axis_length;

   modport source (output valid, output default_axis_length, input ready);
   modport sink   (input valid, input default_axis_length, output ready);
endinterface

/* hdl/fhap_token.sv */
// Value token decoder: atoi-style sign and digit accumulation, saturated magnitude.
// Depends on fhap_pkg.
module fhap_token (
   input  logic                  clock,
   input  logic                  reset,
   input  fhap_pkg::tok_ctl_type ctl,
   input  logic [7:0]            data_byte,
   output fhap_pkg::tok_val_type mid_val
);
   import fhap_pkg::*;

   tok_state_type        st_ff, st_in, st_v;
   logic [MAG_WIDTH-1:0] mag_ff, mag_in, mag_v;
   logic                 neg_ff, neg_in, neg_v;
   logic [PROD_WIDTH-1:0] prod;
   logic                 is_ws, is_sign, is_digit, pre_ws;

   assign is_ws    = (data_byte >= CH_TAB) && (data_byte <= CH_CR);
   assign is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

   always_comb begin
      st_v  = ctl.pre_clear ? TK_PRE : st_ff;
      mag_v = ctl.pre_clear ? '0 : mag_ff;
      neg_v = ctl.pre_clear ? 1'b0 : neg_ff;
      pre_ws = (st_v == TK_PRE) || (st_v == TK_WS);
      // times ten as two shifts, plus the digit
      prod = ({{(PROD_WIDTH-MAG_WIDTH){1'b0}}, mag_v} << 3)
           + ({{(PROD_WIDTH-MAG_WIDTH){1'b0}}, mag_v} << 1)
           + {{(PROD_WIDTH-4){1'b0}}, data_byte[3:0]};
      if (ctl.feed && st_v != TK_STOP) begin
         priority if (data_byte == CH_SPACE) begin
            if (st_v != TK_PRE) st_v = TK_STOP;
         end else if (pre_ws && is_ws) begin
            st_v = TK_WS;
         end else if (pre_ws && is_sign) begin
            neg_v = (data_byte == CH_MINUS);
            st_v  = TK_NUM;
         end else if (is_digit) begin
            mag_v = (prod > {{(PROD_WIDTH-MAG_WIDTH){1'b0}}, MAG_CAP}) ?
                    MAG_CAP : prod[MAG_WIDTH-1:0];
            st_v  = TK_NUM;
         end else begin
            st_v = TK_STOP;
         end
      end
      mid_val.mag = mag_v;
      mid_val.neg = neg_v;
      st_in  = ctl.post_clear ? TK_PRE : st_v;
      mag_in = ctl.post_clear ? '0 : mag_v;
      neg_in = ctl.post_clear ? 1'b0 : neg_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= TK_PRE;
         mag_ff <= '0;
         neg_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

endmodule

/* hdl/fhap_keyword.sv */
// Keyword matcher: tracks which of NAXIS1, NAXIS2 and END the card keyword can still be.
// Depends on fhap_pkg.
module fhap_keyword (
   input  logic                 clock,
   input  logic                 reset,
   input  fhap_pkg::kw_ctl_type ctl,
   input  logic [7:0]           data_byte,
   output fhap_pkg::kw_hit_type hit
);
   import fhap_pkg::*;

   localparam logic [KW_LEN_WIDTH-1:0] NAXIS_LEN = 3'd6;
   localparam logic [KW_LEN_WIDTH-1:0] END_LEN   = 3'd3;
   localparam logic [KW_LEN_WIDTH-1:0] LEN_SAT   = 3'd7;

   logic                    alive1_ff, alive1_in, alive1_v;
   logic                    alive2_ff, alive2_in, alive2_v;
   logic                    alive_end_ff, alive_end_in, alive_end_v;
   logic [KW_LEN_WIDTH-1:0] len_ff, len_in, len_v, idx;

   function automatic logic [7:0] naxis_char(input logic [KW_LEN_WIDTH-1:0] i,
                                             input logic [7:0] last);
      logic [7:0] ch;
      unique case (i)
         3'd0:    ch = "N";
         3'd1:    ch = "A";
         3'd2:    ch = "X";
         3'd3:    ch = "I";
         3'd4:    ch = "S";
         default: ch = last;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] end_char(input logic [KW_LEN_WIDTH-1:0] i);
      logic [7:0] ch;
      unique case (i)
         3'd0:    ch = "E";
         3'd1:    ch = "N";
         default: ch = "D";
      endcase
      return ch;
   endfunction

   always_comb begin
      alive1_v    = ctl.restart ? 1'b1 : alive1_ff;
      alive2_v    = ctl.restart ? 1'b1 : alive2_ff;
      alive_end_v = ctl.restart ? 1'b1 : alive_end_ff;
      len_v       = ctl.restart ? '0 : len_ff;
      idx         = len_v;
      if (ctl.kill) begin
         alive1_v    = 1'b0;
         alive2_v    = 1'b0;
         alive_end_v = 1'b0;
      end else if (ctl.step) begin
         alive1_v    = alive1_v && (idx < NAXIS_LEN) && (data_byte == naxis_char(idx, "1"));
         alive2_v    = alive2_v && (idx < NAXIS_LEN) && (data_byte == naxis_char(idx, "2"));
         alive_end_v = alive_end_v && (idx < END_LEN) && (data_byte == end_char(idx));
         if (len_v < LEN_SAT) len_v = len_v + 3'd1;
      end
      hit.naxis1 = alive1_v && (len_v == NAXIS_LEN);
      hit.naxis2 = alive2_v && (len_v == NAXIS_LEN);
      hit.end_kw = alive_end_v && (len_v == END_LEN);
      alive1_in    = ctl.post_clear ? 1'b1 : alive1_v;
      alive2_in    = ctl.post_clear ? 1'b1 : alive2_v;
      alive_end_in = ctl.post_clear ? 1'b1 : alive_end_v;
      len_in       = ctl.post_clear ? '0 : len_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive1_ff    <= 1'b1;
         alive2_ff    <= 1'b1;
         alive_end_ff <= 1'b1;
         len_ff       <= '0;
      end else begin
         alive1_ff    <= alive1_in;
         alive2_ff    <= alive2_in;
         alive_end_ff <= alive_end_in;
         len_ff       <= len_in;
      end
   end

endmodule

/* hdl/fits_header_axis_parser.sv */
// Header axis-length parser top level: input register, card state, result register.
// Depends on fhap_pkg, fhap_if, fhap_token and fhap_keyword.
//
//   channel  | dir | payload                                            | taken when
//   req_chan | in  | header_byte, start_of_stream                       | valid & ready
//   rsp_chan | out | axis_width, axis_height, *_defaulted              | valid & ready
//   csr_chan | in  | default_axis_length                                | valid (ready tied high)
//
// One header byte per cycle while no result waits untaken: a word is captured in the input
// register, and the card state and the result register are updated from it when it is processed.
// The result register is loaded when the last byte of the block is processed.
// Synchronous reset restores the default length 1024 and clears all parse state.
// Input words stall only while a result waits in the result register untaken.
module fits_header_axis_parser (
   input logic          clock,
   input logic          reset,
   fhap_req_if.sink     req_chan,
   fhap_rsp_if.source   rsp_chan,
   fhap_csr_if.sink     csr_chan
);
   import fhap_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_sos_ff;
   logic       adv, process, act;

   // card and stream state
   logic [POS_WIDTH-1:0]     pos_ff, pos_in, pos_eff;
   logic [NUM_WIDTH-1:0]     num_ff, num_in, num_eff;
   phase_type                phase_ff, phase_in, phase_eff, phase_mid;
   logic                     eq_ff, eq_in, eq_eff, eq_mid;
   logic                     end_ff, end_in, end_eff, end_mid;
   tok_val_type              width_ff, width_in, width_eff, width_mid;
   tok_val_type              height_ff, height_in, height_eff, height_mid;
   logic                     done_ff, done_in;
   logic [DEFAULT_WIDTH-1:0] default_ff;
   logic                     card_end, block_end, out_load;

   // result register
   logic        out_valid_ff, out_valid_in;
   tok_val_type out_width_ff, out_height_ff;

   tok_ctl_type eqt_ctl, kyt_ctl;
   kw_ctl_type  kw_ctl;
   tok_val_type eqt_mid, kyt_mid, value_mid;
   kw_hit_type  kw_hit;
   logic        in_value;

   assign adv     = !out_valid_ff || rsp_chan.ready;
   assign process = in_valid_ff && adv;
   // once the header is done only a restart word does anything
   assign act     = process && (in_sos_ff || !done_ff);

   assign req_chan.ready = !in_valid_ff || adv;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) in_valid_in = 1'b1;
      else if (process)                     in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.header_byte;
         in_sos_ff  <= req_chan.start_of_stream;
      end
   end

   // byte classification and decoder control
   always_comb begin
      pos_eff    = in_sos_ff ? '0 : pos_ff;
      num_eff    = in_sos_ff ? '0 : num_ff;
      phase_eff  = in_sos_ff ? PH_SKIP : phase_ff;
      eq_eff     = in_sos_ff ? 1'b0 : eq_ff;
      end_eff    = in_sos_ff ? 1'b0 : end_ff;
      width_eff  = in_sos_ff ? '0 : width_ff;
      height_eff = in_sos_ff ? '0 : height_ff;
      card_end   = act && (pos_eff == POS_WIDTH'(CARD_LENGTH - 1));

      phase_mid = phase_eff;
      eq_mid    = eq_eff;
      in_value  = 1'b0;
      kw_ctl    = '0;
      kw_ctl.restart    = act && in_sos_ff;
      kw_ctl.post_clear = card_end;

      if (act) begin
         if (in_byte_ff == CH_NUL) begin
            // a zero byte ends the card text
            phase_mid   = PH_DEAD;
            kw_ctl.kill = (phase_eff == PH_SKIP);
         end else begin
            unique case (phase_eff)
               PH_SKIP: begin
                  if (in_byte_ff != CH_SPACE) begin
                     phase_mid   = PH_KEY;
                     kw_ctl.step = 1'b1;
                  end
               end
               PH_KEY: begin
                  if (in_byte_ff == CH_SPACE) phase_mid = PH_VALUE;
                  else                        kw_ctl.step = 1'b1;
               end
               PH_VALUE: begin
                  in_value = 1'b1;
                  if (!eq_eff && in_byte_ff == CH_EQUALS) eq_mid = 1'b1;
               end
               PH_DEAD: begin
                  phase_mid = PH_DEAD;
               end
               default: phase_mid = phase_eff;
            endcase
         end
      end

      kyt_ctl.pre_clear  = act && in_sos_ff;
      kyt_ctl.feed       = in_value;
      kyt_ctl.post_clear = card_end;
      // the first '=' restarts the equals decoder, later bytes feed it
      eqt_ctl.pre_clear  = (act && in_sos_ff) || (in_value && !eq_eff && eq_mid);
      eqt_ctl.feed       = in_value && eq_eff;
      eqt_ctl.post_clear = card_end;
   end

   fhap_token u_eq_token (
      .clock     (clock),
      .reset     (reset),
      .ctl       (eqt_ctl),
      .data_byte (in_byte_ff),
      .mid_val   (eqt_mid)
   );

   fhap_token u_key_token (
      .clock     (clock),
      .reset     (reset),
      .ctl       (kyt_ctl),
      .data_byte (in_byte_ff),
      .mid_val   (kyt_mid)
   );

   fhap_keyword u_keyword (
      .clock     (clock),
      .reset     (reset),
      .ctl       (kw_ctl),
      .data_byte (in_byte_ff),
      .hit       (kw_hit)
   );

   // card finish, counters and result capture
   always_comb begin
      value_mid  = eq_mid ? eqt_mid : kyt_mid;
      end_mid    = end_eff || (card_end && kw_hit.end_kw);
      width_mid  = (card_end && kw_hit.naxis1) ? value_mid : width_eff;
      height_mid = (card_end && kw_hit.naxis2) ? value_mid : height_eff;
      block_end  = card_end && (num_eff == NUM_WIDTH'(CARDS_PER_BLOCK - 1));
      out_load   = block_end && end_mid;

      pos_in    = pos_ff;
      num_in    = num_ff;
      phase_in  = phase_ff;
      eq_in     = eq_ff;
      end_in    = end_ff;
      width_in  = width_ff;
      height_in = height_ff;
      done_in   = done_ff;
      if (act) begin
         pos_in    = card_end ? '0 : pos_eff + POS_WIDTH'(1);
         num_in    = block_end ? '0 : (card_end ? num_eff + NUM_WIDTH'(1) : num_eff);
         phase_in  = card_end ? PH_SKIP : phase_mid;
         eq_in     = card_end ? 1'b0 : eq_mid;
         end_in    = end_mid;
         width_in  = width_mid;
         height_in = height_mid;
         done_in   = out_load;
      end

      out_valid_in = out_valid_ff;
      if (out_load)            out_valid_in = 1'b1;
      else if (rsp_chan.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         num_ff       <= '0;
         phase_ff     <= PH_SKIP;
         eq_ff        <= 1'b0;
         end_ff       <= 1'b0;
         width_ff     <= '0;
         height_ff    <= '0;
         done_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         default_ff   <= DEFAULT_AXIS_RESET;
      end else begin
         pos_ff       <= pos_in;
         num_ff       <= num_in;
         phase_ff     <= phase_in;
         eq_ff        <= eq_in;
         end_ff       <= end_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         done_ff      <= done_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid && csr_chan.ready) default_ff <= csr_chan.default_axis_length;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_width_ff  <= width_mid;
         out_height_ff <= height_mid;
      end
   end

   // resolve sign, saturation and default on the way out
   function automatic logic [AXIS_WIDTH-1:0] resolve(input tok_val_type t,
                                                     input logic [DEFAULT_WIDTH-1:0] dflt);
      logic [AXIS_WIDTH-1:0] r;
      if (t.mag == '0)  r = {{(AXIS_WIDTH-DEFAULT_WIDTH){1'b0}}, dflt};
      else if (t.neg)   r = AXIS_WIDTH'(-t.mag);
      else if (t.mag[MAG_WIDTH-1]) r = AXIS_MAX;
      else              r = AXIS_WIDTH'(t.mag);
      return r;
   endfunction

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.axis_width       = $signed(resolve(out_width_ff, default_ff));
   assign rsp_chan.axis_height      = $signed(resolve(out_height_ff, default_ff));
   assign rsp_chan.width_defaulted  = (out_width_ff.mag == '0);
   assign rsp_chan.height_defaulted = (out_height_ff.mag == '0);

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_WIDTH'(CARD_LENGTH - 1))
      else $error("card position beyond card length");

   a_load_at_block: assert property (@(posedge clock) disable iff (reset)
      out_load |=> done_ff && pos_ff == '0 && num_ff == '0 && out_valid_ff)
      else $error("result loaded away from a block boundary");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done_ff && !(process && in_sos_ff) |=> done_ff)
      else $error("header done cleared without a restart word");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      done_ff && !in_sos_ff |-> !out_load)
      else $error("second result without a restart word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> adv)
      else $error("result register overwritten while held");

endmodule

/* test/fits_header_axis_parser_tb.sv */
// Self-checking testbench for fits_header_axis_parser: header blocks in, axis sizes out.
// Depends on fhap_pkg and the channel interfaces in fhap_if; predicts each result itself.
module fits_header_axis_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fhap_pkg::*;

   localparam int BLOCK_BYTES = CARD_LENGTH * CARDS_PER_BLOCK;
   localparam logic [47:0] KW_NAXIS1 = "NAXIS1";
   localparam logic [47:0] KW_NAXIS2 = "NAXIS2";
   localparam logic [47:0] KW_END    = "END";

   typedef struct packed {
      logic          neg;
      tok_state_type st;
      logic [31:0]   mag;
   } num_token_type;

   typedef struct packed {
      logic signed [AXIS_WIDTH-1:0] width;
      logic signed [AXIS_WIDTH-1:0] height;
      logic                         width_dflt;
      logic                         height_dflt;
   } axis_sizes_type;

   logic clock;
   logic reset;

   fhap_req_if req ();
   fhap_rsp_if rsp ();
   fhap_csr_if csr ();

   fits_header_axis_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // parser state as seen by the testbench
   logic [DEFAULT_WIDTH-1:0]  default_len;
   int                        card_pos;
   int                        card_idx;
   phase_type                 parse_phase;
   logic                      alive_n1, alive_n2, alive_end;
   logic [KW_LEN_WIDTH-1:0]   kw_len;
   num_token_type             tok_eq, tok_kw;
   logic                      eq_seen;
   logic                      end_found;
   logic signed [31:0]        width_seen, height_seen;
   logic                      header_complete;

   axis_sizes_type            expected_sizes[$];
   logic [7:0]                hdr_bytes[$];
   int                        mismatch_count = 0;
   bit                        idle_enable = 1'b1;
   int                        result_hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic num_token_type tok_step(num_token_type t, logic [7:0] c);
      logic [35:0] m;
      if (t.st == TK_STOP) return t;
      if (c == CH_SPACE) begin
         if (t.st != TK_PRE) t.st = TK_STOP;
         return t;
      end
      if ((t.st == TK_PRE || t.st == TK_WS) && c >= CH_TAB && c <= CH_CR) begin
         t.st = TK_WS;
         return t;
      end
      if ((t.st == TK_PRE || t.st == TK_WS) && (c == CH_PLUS || c == CH_MINUS)) begin
         t.neg = (c == CH_MINUS);
         t.st  = TK_NUM;
         return t;
      end
      if (c >= CH_ZERO && c <= CH_NINE) begin
         m = {4'd0, t.mag} * 36'd10 + {28'd0, c - CH_ZERO};
         if (m > {4'd0, MAG_CAP}) m = {4'd0, MAG_CAP};
         t.mag = m[31:0];
         t.st  = TK_NUM;
         return t;
      end
      t.st = TK_STOP;
      return t;
   endfunction

   function automatic logic signed [31:0] tok_value(num_token_type t);
      // magnitude never exceeds 2^31, so negation lands on the minimum at worst
      if (t.neg) return $signed(32'd0 - t.mag);
      if (t.mag > AXIS_MAX) return $signed(AXIS_MAX);
      return $signed(t.mag);
   endfunction

   function automatic bit kw_char_is(logic [47:0] kw, int n, int pos, logic [7:0] c);
      if (pos >= n) return 1'b0;
      return c == kw[8*(n-1-pos) +: 8];
   endfunction

   function automatic void key_char(logic [7:0] c);
      alive_n1  = alive_n1  && kw_char_is(KW_NAXIS1, 6, kw_len, c);
      alive_n2  = alive_n2  && kw_char_is(KW_NAXIS2, 6, kw_len, c);
      alive_end = alive_end && kw_char_is(KW_END, 3, kw_len, c);
      if (kw_len < 7) kw_len++;
   endfunction

   function automatic void clear_card();
      parse_phase = PH_SKIP;
      alive_n1    = 1'b1;
      alive_n2    = 1'b1;
      alive_end   = 1'b1;
      kw_len      = '0;
      tok_eq      = '0;
      tok_kw      = '0;
      eq_seen     = 1'b0;
   endfunction

   function automatic void clear_stream();
      card_pos        = 0;
      card_idx        = 0;
      clear_card();
      end_found       = 1'b0;
      width_seen      = 0;
      height_seen     = 0;
      header_complete = 1'b0;
   endfunction

   function automatic void finish_card();
      logic signed [31:0] v;
      if (parse_phase == PH_SKIP) return;
      if (alive_end && kw_len == 3) end_found = 1'b1;
      v = eq_seen ? tok_value(tok_eq) : tok_value(tok_kw);
      if (alive_n1 && kw_len == 6) width_seen = v;
      if (alive_n2 && kw_len == 6) height_seen = v;
   endfunction

   function automatic void parse_header_byte(logic [7:0] c, bit sos);
      axis_sizes_type res;
      if (sos) clear_stream();
      if (header_complete) return;
      if (c == CH_NUL) begin
         // a zero before any keyword also rules out every keyword
         if (parse_phase == PH_SKIP) begin
            alive_n1  = 1'b0;
            alive_n2  = 1'b0;
            alive_end = 1'b0;
         end
         parse_phase = PH_DEAD;
      end else begin
         case (parse_phase)
            PH_SKIP: begin
               if (c != CH_SPACE) begin
                  parse_phase = PH_KEY;
                  key_char(c);
               end
            end
            PH_KEY: begin
               if (c == CH_SPACE) parse_phase = PH_VALUE;
               else key_char(c);
            end
            PH_VALUE: begin
               tok_kw = tok_step(tok_kw, c);
               if (!eq_seen && c == CH_EQUALS) begin
                  eq_seen = 1'b1;
                  tok_eq  = '0;
               end else if (eq_seen) begin
                  tok_eq = tok_step(tok_eq, c);
               end
            end
            default: ;
         endcase
      end

      if (card_pos + 1 >= CARD_LENGTH) begin
         finish_card();
         clear_card();
         card_pos = 0;
         card_idx++;
         if (card_idx >= CARDS_PER_BLOCK) begin
            card_idx = 0;
            if (end_found) begin
               res.width_dflt  = (width_seen == 0);
               res.height_dflt = (height_seen == 0);
               res.width  = res.width_dflt  ? $signed({16'd0, default_len}) : width_seen;
               res.height = res.height_dflt ? $signed({16'd0, default_len}) : height_seen;
               expected_sizes.push_back(res);
               header_complete = 1'b1;
            end
         end
      end else begin
         card_pos++;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   initial begin
      axis_sizes_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (expected_sizes.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected result: expected none, actual width %0d height %0d",
                        $time, rsp.axis_width, rsp.axis_height);
            end else begin
               want = expected_sizes.pop_front();
               check_field("axis_width", want.width, rsp.axis_width);
               check_field("axis_height", want.height, rsp.axis_height);
               check_field("width_defaulted", want.width_dflt, rsp.width_defaulted);
               check_field("height_defaulted", want.height_dflt, rsp.height_defaulted);
            end
         end
      end
   end

   // result side: random stalls, or a long hold-off while one is requested
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (result_hold_left > 0) begin
            rsp.ready <= 1'b0;
            result_hold_left--;
         end else begin
            rsp.ready <= !idle_enable || ($urandom_range(99) >= 33);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_byte(logic [7:0] c, bit sos);
      while (idle_enable && $urandom_range(99) < 33) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid           <= 1'b1;
      req.header_byte     <= c;
      req.start_of_stream <= sos;
      do @(posedge clock); while (!req.ready);
      parse_header_byte(c, sos);
   endtask

   task automatic send_header();
      foreach (hdr_bytes[i]) send_byte(hdr_bytes[i], i == 0);
      hdr_bytes.delete();
   endtask

   // drop valid, let every result out, then allow for words still in flight
   task automatic wait_drained();
      req.valid <= 1'b0;
      do @(posedge clock); while (expected_sizes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_default_length(logic [DEFAULT_WIDTH-1:0] v);
      csr.valid               <= 1'b1;
      csr.default_axis_length <= v;
      do @(posedge clock); while (!csr.ready);
      default_len = v;
      csr.valid <= 1'b0;
   endtask

   function automatic void add_card(string text);
      for (int i = 0; i < CARD_LENGTH; i++)
         hdr_bytes.push_back(i < text.len() ? text[i] : CH_SPACE);
   endfunction

   function automatic void pad_block();
      while (hdr_bytes.size() % BLOCK_BYTES != 0) add_card("");
   endfunction

   task automatic finish_header();
      pad_block();
      send_header();
   endtask

   function automatic void add_random_card();
      string text;
      string value;
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         for (int i = 0; i < CARD_LENGTH; i++) hdr_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      if (pick < 18) begin
         add_card("");
         return;
      end
      text = "";
      repeat ($urandom_range(2)) text = {text, " "};
      case ($urandom_range(9))
         0, 1, 2: text = {text, "NAXIS1"};
         3, 4, 5: text = {text, "NAXIS2"};
         6:       text = {text, "NAXIS"};
         7:       text = {text, "BITPIX"};
         8:       text = {text, "NAXIS3"};
         default: text = {text, "NAXIS10"};
      endcase
      repeat ($urandom_range(3, 1)) text = {text, " "};
      pick = $urandom_range(5);
      if (pick >= 2) text = {text, "= "};
      else if (pick == 1) text = {text, "="};
      case ($urandom_range(8))
         0:       value = $sformatf("%0d", $urandom_range(4096));
         1:       value = $sformatf("%0d", $urandom());
         2:       value = $sformatf("-%0d", $urandom());
         3:       value = $sformatf("+%0d", $urandom_range(99999));
         4:       value = "-99999999999999999999";
         5:       value = {"\t", $sformatf("%0d", $urandom_range(65535))};
         6:       value = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(99));
         7:       value = "";
         default: value = "0";
      endcase
      text = {text, value};
      if ($urandom_range(2) == 0) text = {text, " / axis length"};
      add_card(text);
   endfunction

   task automatic send_random_header();
      int blocks;
      int end_card;
      int shape;
      int keep;
      blocks   = ($urandom_range(7) == 0) ? 2 : 1;
      end_card = $urandom_range(blocks * CARDS_PER_BLOCK - 1, (blocks - 1) * CARDS_PER_BLOCK);
      // most headers are whole; some lack END, some are cut short
      shape    = $urandom_range(11);
      for (int k = 0; k < blocks * CARDS_PER_BLOCK; k++) begin
         if (k == end_card && shape != 0) add_card($urandom_range(1) ? "END" : "  END");
         else add_random_card();
      end
      if (shape == 1) begin
         keep = $urandom_range(hdr_bytes.size() - 1, 1);
         while (hdr_bytes.size() > keep) void'(hdr_bytes.pop_back());
      end
      send_header();
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(40, 1)) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_default();
      add_card("END");
      finish_header();
      add_card("SIMPLE  =                    T");
      add_card("NAXIS1  =                  640");
      add_card("NAXIS2  =                  480");
      add_card("END");
      finish_header();
      wait_drained();
   endtask

   task automatic test_value_decoding();
      add_card("NAXIS1  = 2147483647");
      add_card("NAXIS2  = -2147483648");
      add_card("END");
      finish_header();
      add_card("NAXIS1 = 2147483648");
      add_card("NAXIS2 = -99999999999");
      add_card("END");
      finish_header();
      add_card("NAXIS1 = +00042abc");
      add_card("NAXIS2 =\t\r-17");
      add_card("END");
      finish_header();
      // no equals sign: token after the keyword, or nothing at all
      add_card("  NAXIS1 321 / no equals");
      add_card("NAXIS2");
      add_card("   END");
      finish_header();
      add_card("NAXIS1 = 12 = 34");
      add_card("NAXIS2 = 1 2");
      add_card("END = 3");
      finish_header();
      add_card("NAXIS1 = 0");
      add_card("NAXIS2 = -5");
      add_card("END");
      finish_header();
      wait_drained();
   endtask

   task automatic test_keyword_matching();
      add_card("NAXIS12 = 9");
      add_card("NAXIS = 9");
      add_card("naxis1 = 9");
      add_card("NAXIS1=9");
      add_card("ENDX");
      add_card("EN");
      add_card("END");
      finish_header();
      // later cards override, and cards after END still count
      add_card("NAXIS1 = 5");
      add_card("END");
      add_card("NAXIS1 = 6");
      add_card("NAXIS2 = 7");
      finish_header();
      wait_drained();
   endtask

   task automatic test_zero_byte_two_blocks();
      int base;
      base = hdr_bytes.size();
      add_card("NAXIS1  = 77");
      hdr_bytes[base + 10] = CH_NUL;
      base = hdr_bytes.size();
      add_card("NAXIS2  = 55 / x");
      hdr_bytes[base + 13] = CH_NUL;
      base = hdr_bytes.size();
      add_card(" END");
      hdr_bytes[base] = CH_NUL;
      base = hdr_bytes.size();
      add_card("END");
      hdr_bytes[base + 2] = CH_NUL;
      pad_block();
      add_card("END");
      finish_header();
      wait_drained();
   endtask

   task automatic test_restart();
      add_card("NAXIS1 = 11");
      add_card("END");
      pad_block();
      while (hdr_bytes.size() > BLOCK_BYTES / 2) void'(hdr_bytes.pop_back());
      send_header();
      add_card("NAXIS1 = 22");
      add_card("END");
      finish_header();
      // words after a result are dropped until the next start of stream
      repeat (200) send_byte(8'($urandom_range(255)), 1'b0);
      add_card("NAXIS2 = 33");
      add_card("END");
      finish_header();
      wait_drained();
   endtask

   task automatic test_default_register();
      write_default_length('0);
      add_card("END");
      finish_header();
      wait_drained();
      write_default_length('1);
      add_card("NAXIS1 = 0");
      add_card("NAXIS2 = 300");
      add_card("END");
      finish_header();
      wait_drained();
      write_default_length(16'd1);
      add_card("NAXIS2 = 4");
      add_card("END");
      finish_header();
      wait_drained();
   endtask

   task automatic test_backpressure();
      idle_enable      = 1'b0;
      result_hold_left = 4000;
      repeat (3) begin
         add_card($sformatf("NAXIS1 = %0d", $urandom_range(9999)));
         add_card("END");
         finish_header();
      end
      wait_drained();
      idle_enable = 1'b1;
   endtask

   task automatic test_random_headers();
      for (int n = 0; n < 40; n++) begin
         if (n % 8 == 7) begin
            wait_drained();
            case ($urandom_range(3))
               0:       write_default_length('0);
               1:       write_default_length('1);
               default: write_default_length(16'($urandom_range(65535)));
            endcase
         end
         idle_enable = !(n >= 16 && n < 22);
         send_random_header();
      end
      idle_enable = 1'b1;
      wait_drained();
   endtask

   initial begin
      reset                   <= 1'b1;
      req.valid               <= 1'b0;
      req.header_byte         <= '0;
      req.start_of_stream     <= 1'b0;
      csr.valid               <= 1'b0;
      csr.default_axis_length <= '0;
      default_len = DEFAULT_AXIS_RESET;
      clear_stream();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default();
      test_value_decoding();
      test_keyword_matching();
      test_zero_byte_two_blocks();
      test_restart();
      test_default_register();
      test_backpressure();
      test_random_headers();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_sizes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
hdl/fhap_pkg.sv
hdl/fhap_if.sv
hdl/fhap_token.sv
hdl/fhap_keyword.sv
hdl/fits_header_axis_parser.sv
test/fits_header_axis_parser_tb.sv
